FILE: hw/rtl/bounded_stack_with_min_reverse_core_macros.svh
// assertion macros for the bounded stack core
`ifndef BOUNDED_STACK_WITH_MIN_REVERSE_CORE_MACROS_SVH
`define BOUNDED_STACK_WITH_MIN_REVERSE_CORE_MACROS_SVH

// plain property, checked at every clock outside reset
`define BSMR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// next-cycle implication, checked outside reset
`define BSMR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/bsmr_pkg.sv
// shared constants and codes for the bounded stack core
package bsmr_pkg;

	localparam int DEPTH_DEF = 64;

	localparam int REQ_W   = 3;
	localparam int VAL_W   = 32;
	localparam int ST_W    = 2;
	localparam int CNT_W   = 7;
	localparam int CAP_W   = 7;
	localparam int M_DATA_W = ((VAL_W + CNT_W + 7) / 8) * 8;

	localparam logic [CAP_W-1:0] CAP_RST = 7'd64;

	localparam logic [REQ_W-1:0] REQ_PUSH = 3'd0;
	localparam logic [REQ_W-1:0] REQ_POP  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_PEEK = 3'd2;
	localparam logic [REQ_W-1:0] REQ_REV  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_MIN  = 3'd4;

	localparam logic [ST_W-1:0] ST_OK  = 2'd0;
	localparam logic [ST_W-1:0] ST_OVF = 2'd1;
	localparam logic [ST_W-1:0] ST_UND = 2'd2;

endpackage

FILE: hw/rtl/bounded_stack_with_min_reverse_core.sv
// bounded lifo stack of signed words with reverse and minimum, top level
//
//  channel | direction | tdata (low bit up)                 | tuser
//  s_*     | in        | push_value[31:0]                   | req_type[2:0]
//  m_*     | out       | result_value[31:0], entry_count[6:0], pad | status[1:0]
//  cfg_*   | in        | cfg_wdata = capacity_in_use[6:0]   | -
//
//  push, reverse, refused and unknown requests: answered straight from the idle state
//  pop and peek: through the read state, one memory read of the top entry
//  minimum: through the scan state, one read per held entry on the single read port
//  reverse moves only the bottom and next pointers and flips the walk direction
//  a new transfer is taken while idle and the output register is empty or being drained
//  reset clears the count and pointers; the word memory is not cleared
`include "bounded_stack_with_min_reverse_core_macros.svh"

module bounded_stack_with_min_reverse_core #(
	parameter int DEPTH = bsmr_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bsmr_pkg::VAL_W-1:0]    s_tdata,   // push_value
	input  logic [bsmr_pkg::REQ_W-1:0]    s_tuser,   // req_type
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bsmr_pkg::M_DATA_W-1:0] m_tdata,   // result_value, entry_count, zero pad
	output logic [bsmr_pkg::ST_W-1:0]     m_tuser,   // status
	input  logic                          cfg_we,
	input  logic [bsmr_pkg::CAP_W-1:0]    cfg_wdata  // capacity_in_use
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > bsmr_pkg::CAP_W) ? CW : bsmr_pkg::CAP_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
	localparam int PAD_W = bsmr_pkg::M_DATA_W - bsmr_pkg::VAL_W - bsmr_pkg::CNT_W;

	typedef enum logic [1:0] {
		IDLE,
		READ,
		SCAN
	} state_t;

	state_t                       state_q;
	logic [CW-1:0]                fill_q;
	logic [AW-1:0]                bot_q;
	logic [AW-1:0]                nxt_q;
	logic                         dir_q;
	logic [bsmr_pkg::CAP_W-1:0]   cap_q;
	logic [AW-1:0]                scan_addr_q;
	logic [CW-1:0]                left_q;
	logic                         first_q;
	logic [bsmr_pkg::VAL_W-1:0]   min_q;
	logic                         out_vld_q;
	logic [bsmr_pkg::VAL_W-1:0]   out_val_q;
	logic [bsmr_pkg::ST_W-1:0]    out_st_q;
	logic [bsmr_pkg::CNT_W-1:0]   out_cnt_q;

	logic [bsmr_pkg::VAL_W-1:0]   mem [DEPTH];
	logic [bsmr_pkg::VAL_W-1:0]   rd_data_s1;
	logic [AW-1:0]                mem_raddr;
	logic                         mem_we;

	logic                         accept;
	logic                         empty;
	logic                         full;
	logic [AW-1:0]                top_addr;
	logic [bsmr_pkg::VAL_W-1:0]   scan_min;

	function automatic logic [AW-1:0] step(input logic [AW-1:0] a, input logic down);
		logic [AW-1:0] r;
		if (down) begin
			r = (a == '0) ? LAST_ADDR : a - 1'b1;
		end else begin
			r = (a == LAST_ADDR) ? '0 : a + 1'b1;
		end
		return r;
	endfunction

	assign s_tready = (state_q == IDLE) && (!out_vld_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign empty    = (fill_q == '0);
	assign full     = (XW'(fill_q) >= XW'(cap_q)) || (fill_q == FULL_CNT);
	assign top_addr = step(nxt_q, !dir_q);
	assign mem_we   = accept && (s_tuser == bsmr_pkg::REQ_PUSH) && !full;
	assign scan_min = (first_q || ($signed(rd_data_s1) < $signed(min_q))) ? rd_data_s1 : min_q;

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_cnt_q, out_val_q};
	assign m_tuser  = out_st_q;

	always_comb begin
		if (state_q == IDLE) begin
			mem_raddr = (s_tuser == bsmr_pkg::REQ_MIN) ? bot_q : top_addr;
		end else begin
			mem_raddr = scan_addr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[nxt_q] <= s_tdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			fill_q      <= '0;
			bot_q       <= '0;
			nxt_q       <= '0;
			dir_q       <= 1'b0;
			cap_q       <= bsmr_pkg::CAP_RST;
			scan_addr_q <= '0;
			left_q      <= '0;
			first_q     <= 1'b0;
			min_q       <= '0;
			out_vld_q   <= 1'b0;
			out_val_q   <= '0;
			out_st_q    <= bsmr_pkg::ST_OK;
			out_cnt_q   <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (out_vld_q && m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						out_val_q <= '0;
						out_st_q  <= bsmr_pkg::ST_OK;
						out_cnt_q <= bsmr_pkg::CNT_W'(fill_q);
						unique case (s_tuser)
							bsmr_pkg::REQ_PUSH: begin
								out_vld_q <= 1'b1;
								if (full) begin
									out_st_q <= bsmr_pkg::ST_OVF;
								end else begin
									fill_q    <= fill_q + 1'b1;
									nxt_q     <= step(nxt_q, dir_q);
									out_cnt_q <= bsmr_pkg::CNT_W'(fill_q + 1'b1);
								end
							end
							bsmr_pkg::REQ_POP, bsmr_pkg::REQ_PEEK: begin
								if (empty) begin
									out_vld_q <= 1'b1;
									out_st_q  <= bsmr_pkg::ST_UND;
								end else begin
									state_q <= READ;
									if (s_tuser == bsmr_pkg::REQ_POP) begin
										fill_q <= fill_q - 1'b1;
										nxt_q  <= top_addr;
									end
								end
							end
							bsmr_pkg::REQ_REV: begin
								out_vld_q <= 1'b1;
								if (!empty) begin
									bot_q <= top_addr;
									nxt_q <= step(bot_q, !dir_q);
									dir_q <= !dir_q;
								end
							end
							bsmr_pkg::REQ_MIN: begin
								if (empty) begin
									out_vld_q <= 1'b1;
									out_st_q  <= bsmr_pkg::ST_UND;
								end else begin
									state_q     <= SCAN;
									scan_addr_q <= step(bot_q, dir_q);
									left_q      <= fill_q - 1'b1;
									first_q     <= 1'b1;
								end
							end
							default: begin
								out_vld_q <= 1'b1;
							end
						endcase
					end
				end
				READ: begin
					out_vld_q <= 1'b1;
					out_val_q <= rd_data_s1;
					out_st_q  <= bsmr_pkg::ST_OK;
					out_cnt_q <= bsmr_pkg::CNT_W'(fill_q);
					state_q   <= IDLE;
				end
				SCAN: begin
					min_q   <= scan_min;
					first_q <= 1'b0;
					if (left_q == '0) begin
						out_vld_q <= 1'b1;
						out_val_q <= scan_min;
						out_st_q  <= bsmr_pkg::ST_OK;
						out_cnt_q <= bsmr_pkg::CNT_W'(fill_q);
						state_q   <= IDLE;
					end else begin
						scan_addr_q <= step(scan_addr_q, dir_q);
						left_q      <= left_q - 1'b1;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	`BSMR_ASSERT(a_fill_bound, fill_q <= FULL_CNT, "fill count above depth")
	`BSMR_ASSERT(a_scan_nonempty, (state_q != SCAN) || (fill_q != '0) && (left_q < fill_q),
		"minimum walk on an empty stack")
	`BSMR_ASSERT_IMPL(a_push_grows, mem_we, fill_q == CW'($past(fill_q) + 1'b1),
		"accepted push did not grow the count")

endmodule

FILE: tb/bounded_stack_with_min_reverse_core_tb.sv
// testbench for the bounded stack core: directed and random requests checked by a built-in predictor
`timescale 1ns / 100ps

module bounded_stack_with_min_reverse_core_tb;

	localparam int DEPTH = bsmr_pkg::DEPTH_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [bsmr_pkg::REQ_W-1:0] REQ_RSVD5 = 3'd5;
	localparam logic [bsmr_pkg::REQ_W-1:0] REQ_RSVD6 = 3'd6;
	localparam logic [bsmr_pkg::REQ_W-1:0] REQ_RSVD7 = 3'd7;

	typedef struct packed {
		logic [bsmr_pkg::VAL_W-1:0] value;
		logic [bsmr_pkg::ST_W-1:0]  status;
		logic [bsmr_pkg::CNT_W-1:0] count;
	} stack_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [bsmr_pkg::VAL_W-1:0]    s_tdata;   // push_value
	logic [bsmr_pkg::REQ_W-1:0]    s_tuser;   // req_type
	logic                          m_tvalid;
	logic                          m_tready;
	logic [bsmr_pkg::M_DATA_W-1:0] m_tdata;   // result_value, entry_count, zero pad
	logic [bsmr_pkg::ST_W-1:0]     m_tuser;   // status
	logic                          cfg_we;
	logic [bsmr_pkg::CAP_W-1:0]    cfg_wdata; // capacity_in_use

	logic signed [bsmr_pkg::VAL_W-1:0] model_words [DEPTH];
	int                                model_fill;
	int                                model_capacity;
	stack_result_t                     expected_results [$];

	int error_count;
	int cycle_count;
	int burst_left;
	int hold_left;
	int stretch_left;
	int stall_pct;

	bounded_stack_with_min_reverse_core #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic stack_result_t predict_request(logic [bsmr_pkg::REQ_W-1:0] req,
			logic [bsmr_pkg::VAL_W-1:0] val);
		stack_result_t                     r;
		int                                limit;
		int                                lo;
		int                                hi;
		logic signed [bsmr_pkg::VAL_W-1:0] swap;
		logic signed [bsmr_pkg::VAL_W-1:0] low_word;
		r.value  = '0;
		r.status = bsmr_pkg::ST_OK;
		limit    = (model_capacity > DEPTH) ? DEPTH : model_capacity;
		case (req)
			bsmr_pkg::REQ_PUSH: begin
				if (model_fill >= limit) begin
					r.status = bsmr_pkg::ST_OVF;
				end else begin
					model_words[model_fill] = val;
					model_fill++;
				end
			end
			bsmr_pkg::REQ_POP, bsmr_pkg::REQ_PEEK: begin
				if (model_fill == 0) begin
					r.status = bsmr_pkg::ST_UND;
				end else begin
					r.value = model_words[model_fill-1];
					if (req == bsmr_pkg::REQ_POP) model_fill--;
				end
			end
			bsmr_pkg::REQ_REV: begin
				lo = 0;
				hi = model_fill - 1;
				while (lo < hi) begin
					swap            = model_words[lo];
					model_words[lo] = model_words[hi];
					model_words[hi] = swap;
					lo++;
					hi--;
				end
			end
			bsmr_pkg::REQ_MIN: begin
				if (model_fill == 0) begin
					r.status = bsmr_pkg::ST_UND;
				end else begin
					low_word = model_words[0];
					for (int i = 1; i < model_fill; i++)
						if (model_words[i] < low_word) low_word = model_words[i];
					r.value = low_word;
				end
			end
			default: ;
		endcase
		r.count = bsmr_pkg::CNT_W'(model_fill);
		return r;
	endfunction

	task automatic send_request(logic [bsmr_pkg::REQ_W-1:0] req,
			logic [bsmr_pkg::VAL_W-1:0] val);
		int gap;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= val;
		s_tuser  <= req;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		expected_results.push_back(predict_request(req, val));
	endtask

	task automatic drain_results(int settle);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_capacity(logic [bsmr_pkg::CAP_W-1:0] cap);
		drain_results(4);
		cfg_wdata <= cap;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_capacity = cap;
	endtask

	function automatic logic [bsmr_pkg::VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2, 3:    return bsmr_pkg::VAL_W'($urandom_range(0, 16)) - 32'd8;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [bsmr_pkg::REQ_W-1:0] pick_request();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return bsmr_pkg::REQ_PUSH;
		if (r < 58) return bsmr_pkg::REQ_POP;
		if (r < 68) return bsmr_pkg::REQ_PEEK;
		if (r < 80) return bsmr_pkg::REQ_MIN;
		if (r < 94) return bsmr_pkg::REQ_REV;
		return bsmr_pkg::REQ_W'($urandom_range(5, 7));
	endfunction

	task automatic check_field(string name, logic [bsmr_pkg::VAL_W-1:0] exp,
			logic [bsmr_pkg::VAL_W-1:0] act);
		if (exp !== act) begin
			$error("%s mismatch: expected %0h, actual %0h", name, exp, act);
			error_count++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		stack_result_t exp;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected: value %0h status %0d",
					m_tdata[bsmr_pkg::VAL_W-1:0], m_tuser);
				error_count++;
			end else begin
				exp = expected_results.pop_front();
				check_field("result_value", exp.value, m_tdata[bsmr_pkg::VAL_W-1:0]);
				check_field("status", bsmr_pkg::VAL_W'(exp.status),
					bsmr_pkg::VAL_W'(m_tuser));
				check_field("entry_count", bsmr_pkg::VAL_W'(exp.count),
					bsmr_pkg::VAL_W'(m_tdata[bsmr_pkg::VAL_W+bsmr_pkg::CNT_W-1:bsmr_pkg::VAL_W]));
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (stretch_left <= 0) begin
				stretch_left = $urandom_range(16, 80);
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 25;
					2: stall_pct = 50;
					default: stall_pct = 85;
				endcase
			end
			stretch_left--;
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic test_reset_state();
		send_request(bsmr_pkg::REQ_POP, 32'h1234_5678);
		send_request(bsmr_pkg::REQ_PEEK, 32'hffff_ffff);
		send_request(bsmr_pkg::REQ_MIN, 32'h0);
		send_request(bsmr_pkg::REQ_REV, 32'h0);
		send_request(REQ_RSVD5, 32'h5555_5555);
		send_request(REQ_RSVD6, 32'haaaa_aaaa);
		send_request(REQ_RSVD7, 32'hffff_ffff);
		send_request(bsmr_pkg::REQ_PUSH, 32'h7fff_ffff);
		send_request(bsmr_pkg::REQ_REV, 32'h0);
		send_request(bsmr_pkg::REQ_PUSH, 32'h8000_0000);
		send_request(bsmr_pkg::REQ_PUSH, 32'hffff_ffff);
		send_request(bsmr_pkg::REQ_PUSH, 32'h0000_0000);
		send_request(bsmr_pkg::REQ_PEEK, 32'h0);
		send_request(bsmr_pkg::REQ_MIN, 32'h0);
		send_request(bsmr_pkg::REQ_REV, 32'h0);
		send_request(bsmr_pkg::REQ_PEEK, 32'h0);
		send_request(REQ_RSVD7, 32'h0);
		send_request(bsmr_pkg::REQ_POP, 32'h0);
		send_request(bsmr_pkg::REQ_MIN, 32'h0);
		send_request(bsmr_pkg::REQ_POP, 32'h0);
		send_request(bsmr_pkg::REQ_POP, 32'h0);
		send_request(bsmr_pkg::REQ_POP, 32'h0);
		send_request(bsmr_pkg::REQ_POP, 32'h0);
	endtask

	task automatic test_capacity_limits();
		write_capacity(7'd0);
		send_request(bsmr_pkg::REQ_PUSH, 32'h1);
		send_request(bsmr_pkg::REQ_PUSH, 32'h2);
		send_request(bsmr_pkg::REQ_POP, 32'h0);
		write_capacity(7'd1);
		send_request(bsmr_pkg::REQ_PUSH, 32'hdead_beef);
		send_request(bsmr_pkg::REQ_PUSH, 32'h3);
		send_request(bsmr_pkg::REQ_MIN, 32'h0);
		send_request(bsmr_pkg::REQ_POP, 32'h0);
		write_capacity(7'd127);
		for (int i = 0; i < DEPTH + 2; i++) send_request(bsmr_pkg::REQ_PUSH, pick_value());
		send_request(bsmr_pkg::REQ_MIN, 32'h0);
		send_request(bsmr_pkg::REQ_REV, 32'h0);
		send_request(bsmr_pkg::REQ_PEEK, 32'h0);
		for (int i = 0; i < DEPTH + 1; i++) send_request(bsmr_pkg::REQ_POP, 32'h0);
	endtask

	task automatic test_capacity_below_fill();
		write_capacity(7'd64);
		for (int i = 0; i < 10; i++) send_request(bsmr_pkg::REQ_PUSH, pick_value());
		write_capacity(7'd3);
		send_request(bsmr_pkg::REQ_PUSH, 32'h11);
		send_request(bsmr_pkg::REQ_PEEK, 32'h0);
		send_request(bsmr_pkg::REQ_REV, 32'h0);
		send_request(bsmr_pkg::REQ_MIN, 32'h0);
		for (int i = 0; i < 8; i++) send_request(bsmr_pkg::REQ_POP, 32'h0);
		send_request(bsmr_pkg::REQ_PUSH, 32'h22);
		send_request(bsmr_pkg::REQ_PUSH, 32'h33);
		send_request(bsmr_pkg::REQ_MIN, 32'h0);
	endtask

	task automatic test_output_backpressure();
		write_capacity(7'd64);
		hold_left = 400;
		for (int i = 0; i < 30; i++)
			send_request((i % 5 == 4) ? bsmr_pkg::REQ_PEEK : bsmr_pkg::REQ_PUSH, pick_value());
		send_request(bsmr_pkg::REQ_MIN, 32'h0);
		for (int i = 0; i < 12; i++) send_request(bsmr_pkg::REQ_POP, 32'h0);
	endtask

	task automatic test_random_mix();
		logic [bsmr_pkg::CAP_W-1:0] caps [7];
		caps = '{7'd64, 7'd127, 7'd16, 7'd2, 7'd40, 7'd1, 7'd64};
		foreach (caps[k]) begin
			write_capacity(caps[k]);
			for (int i = 0; i < 30; i++) send_request(pick_request(), pick_value());
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = bsmr_pkg::REQ_PUSH;
		m_tready       = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = bsmr_pkg::CAP_RST;
		error_count    = 0;
		burst_left     = 0;
		hold_left      = 0;
		stretch_left   = 0;
		stall_pct      = 0;
		model_fill     = 0;
		model_capacity = bsmr_pkg::CAP_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_capacity_limits();
		test_capacity_below_fill();
		test_output_backpressure();
		test_random_mix();
		drain_results(DEPTH + 8);

		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
